/* rtl/size_class_free_stack_allocator_unit_defines.svh */
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SIZE_CLASS_FREE_STACK_ALLOCATOR_UNIT_DEFINES_SVH
`define SIZE_CLASS_FREE_STACK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define SCFSA_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCFSA_CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/scfsa_pkg.sv */
// Types and codes for the size-class free stack allocator.
// No dependencies; imported by the class decoder and the top level.
`default_nettype none

package scfsa_pkg;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_FILL,
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [2:0] cls;
    logic       too_large;
  } class_info_t;

endpackage

`default_nettype wire

/* rtl/scfsa_class.sv */
// Size class decoder: bit length of size-1, then class thresholds.
// Depends on scfsa_pkg.
`default_nettype none

module scfsa_class
  import scfsa_pkg::*;
#(
  parameter int CLASS_COUNT  = 6,
  parameter int MIN_BITS     = 8,
  parameter int CLASS_STRIDE = 2
) (
  input  wire logic [31:0] size,
  output class_info_t      info
);

  logic [31:0] size_m1;
  logic [6:0]  len;
  logic [2:0]  cls;

  assign size_m1 = size - 32'd1;

  always_comb begin
    len = 7'd0;
    if (size == 32'd0) begin
      len = 7'd64;
    end else begin
      for (int i = 0; i < 32; i++) begin
        if (size_m1[i]) begin
          len = 7'(i + 1);
        end
      end
    end
  end

  // class >= k exactly when len reaches MIN_BITS + (k-1)*CLASS_STRIDE
  always_comb begin
    cls = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if ({1'b0, len} >= 8'(MIN_BITS + (k - 1) * CLASS_STRIDE)) begin
        cls = cls + 3'd1;
      end
    end
  end

  assign info.cls       = cls;
  assign info.too_large = (size == 32'd0) || (cls >= 3'(CLASS_COUNT));

endmodule

`default_nettype wire

/* rtl/size_class_free_stack_allocator_unit.sv */
// Allocate: the stack RAM is read in S_EXEC and the result loaded in S_RESP, so a new beat waits for the read data.
// Free and errors: result loaded in S_EXEC, one per cycle while the output is not stalled.
// One shared single-port stack RAM; per-class counts in flip-flops.
// Reset: layout fill of all CLASS_COUNT*SLOTS_PER_ROW stack entries (384 by default), input stalled.
// Depends on scfsa_pkg, scfsa_class and the defines header.
`default_nettype none
`include "size_class_free_stack_allocator_unit_defines.svh"

module size_class_free_stack_allocator_unit
  import scfsa_pkg::*;
#(
  parameter int SLOTS_PER_ROW = 64,
  parameter int CLASS_COUNT   = 6,
  parameter int MIN_BITS      = 8,
  parameter int CLASS_STRIDE  = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [31:0] in_request_size,
  input  wire logic [31:0] in_free_offset,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_block_offset,
  output logic [2:0]       out_size_class,
  output logic [1:0]       out_status
);

  localparam int DEPTH = CLASS_COUNT * SLOTS_PER_ROW;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SLOTS_PER_ROW + 1);
  localparam int SW    = $clog2(SLOTS_PER_ROW);
  localparam int RW    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

  state_t            state_r, state_nxt;
  class_info_t       info;
  logic              in_acc;
  logic              func_r;
  logic [31:0]       foff_r;
  logic [2:0]        cls_r;
  logic              big_r;
  logic [CW-1:0]     count_r [CLASS_COUNT];
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_nxt;
  logic              cnt_we;
  logic [RW-1:0]     cls_idx;
  logic [AW:0]       row_base;
  logic [AW:0]       push_addr;
  logic [AW:0]       pop_addr;

  logic [31:0]       mem [DEPTH];
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [31:0]       mem_wdata;
  logic [31:0]       rd_data_r;

  logic [AW-1:0]     fill_addr_r;
  logic [SW-1:0]     fill_col_r;
  logic [RW-1:0]     fill_row_r;
  logic [31:0]       fill_off_r;
  logic [31:0]       fill_blk_r;
  logic              fill_in_layout;
  logic              fill_last;
  logic              fill_step;

  logic              can_load;
  logic              ld_out;
  logic [31:0]       ld_off;
  status_t           ld_status;
  status_t           exec_status;
  logic              pop_ok, push_ok;

  logic              out_valid_r;
  logic [31:0]       out_off_r;
  logic [2:0]        out_cls_r;
  status_t           out_status_r;

  scfsa_class #(
    .CLASS_COUNT  (CLASS_COUNT),
    .MIN_BITS     (MIN_BITS),
    .CLASS_STRIDE (CLASS_STRIDE)
  ) u_class (
    .size (in_request_size),
    .info (info)
  );

  assign in_acc  = in_valid && !in_stall;
  assign cls_idx = cls_r[RW-1:0];
  assign cnt     = count_r[cls_idx];

  assign row_base  = (AW + 1)'(cls_idx) * (AW + 1)'(SLOTS_PER_ROW);
  assign push_addr = row_base + (AW + 1)'(cnt);
  assign pop_addr  = row_base + (AW + 1)'(cnt) - (AW + 1)'(1);

  assign fill_in_layout = CW'(fill_col_r) < (CW'(SLOTS_PER_ROW) >> fill_row_r);
  assign fill_last      = fill_addr_r == AW'(DEPTH - 1);

  assign can_load = !out_valid_r || !out_stall;

  always_comb begin
    exec_status = STAT_OK;
    pop_ok      = 1'b0;
    push_ok     = 1'b0;
    priority if (big_r) begin
      exec_status = STAT_TOO_LARGE;
    end else if (func_r == FUNC_ALLOC) begin
      if (cnt == '0) begin
        exec_status = STAT_EMPTY;
      end else begin
        pop_ok = 1'b1;
      end
    end else begin
      if (cnt == CW'(SLOTS_PER_ROW)) begin
        exec_status = STAT_FULL;
      end else begin
        push_ok = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    ld_out    = 1'b0;
    ld_off    = '0;
    ld_status = STAT_OK;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = push_addr[AW-1:0];
    mem_wdata = foff_r;
    cnt_we    = 1'b0;
    cnt_nxt   = cnt;
    fill_step = 1'b0;
    unique case (state_r)
      S_FILL: begin
        fill_step = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = fill_addr_r;
        mem_wdata = fill_in_layout ? fill_off_r : '0;
        if (fill_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (pop_ok) begin
          mem_re    = 1'b1;
          mem_addr  = pop_addr[AW-1:0];
          cnt_we    = 1'b1;
          cnt_nxt   = cnt - CW'(1);
          state_nxt = S_RESP;
        end else if (can_load) begin
          ld_out    = 1'b1;
          ld_status = exec_status;
          if (push_ok) begin
            mem_we  = 1'b1;
            cnt_we  = 1'b1;
            cnt_nxt = cnt + CW'(1);
          end
          in_stall  = 1'b0;
          state_nxt = in_valid ? S_EXEC : S_IDLE;
        end
      end
      S_RESP: begin
        if (can_load) begin
          ld_out    = 1'b1;
          ld_off    = rd_data_r;
          in_stall  = 1'b0;
          state_nxt = in_valid ? S_EXEC : S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      foff_r <= in_free_offset;
      cls_r  <= info.cls;
      big_r  <= info.too_large;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < CLASS_COUNT; r++) begin
        count_r[r] <= CW'(SLOTS_PER_ROW >> r);
      end
    end else if (cnt_we) begin
      count_r[cls_idx] <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_addr_r <= '0;
      fill_col_r  <= '0;
      fill_row_r  <= '0;
      fill_off_r  <= '0;
      fill_blk_r  <= 32'd1 << (MIN_BITS - 1);
    end else if (fill_step) begin
      fill_addr_r <= fill_addr_r + AW'(1);
      if (fill_in_layout) begin
        fill_off_r <= fill_off_r + fill_blk_r;
      end
      if (fill_col_r == SW'(SLOTS_PER_ROW - 1)) begin
        fill_col_r <= '0;
        fill_row_r <= fill_row_r + RW'(1);
        fill_blk_r <= fill_blk_r << CLASS_STRIDE;
      end else begin
        fill_col_r <= fill_col_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ld_out || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_off_r    <= ld_off;
      out_cls_r    <= cls_r;
      out_status_r <= ld_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_offset = out_off_r;
  assign out_size_class   = out_cls_r;
  assign out_status       = out_status_r;

  `SCFSA_CHK_NOW(a_fill_blocks_input, state_r == S_FILL, in_stall, "beat taken during fill")
  `SCFSA_CHK_NOW(a_one_port_access, mem_we || mem_re, !(mem_we && mem_re), "RAM port clash")
  `SCFSA_CHK_NXT(a_pop_then_resp, state_r == S_EXEC && mem_re, state_r == S_RESP,
    "pop did not wait for read data")
  `SCFSA_CHK_NOW(a_count_bound, cnt_we, cnt_nxt <= CW'(SLOTS_PER_ROW), "count past row size")

endmodule

`default_nettype wire

/* sim/size_class_free_stack_allocator_unit_tb.sv */
// Self-checking bench for size_class_free_stack_allocator_unit: directed rows, then random
// allocate/free traffic under varied idling, each result checked against a local allocator or a typed row.
// Depends on scfsa_pkg and the allocator RTL.

module size_class_free_stack_allocator_unit_tb;
  import scfsa_pkg::*;

  localparam int SLOTS_PER_ROW = 64;
  localparam int CLASS_COUNT   = 6;
  localparam int MIN_BITS      = 8;
  localparam int CLASS_STRIDE  = 2;
  localparam int STACK_DEPTH   = CLASS_COUNT * SLOTS_PER_ROW;
  localparam int NUM_DIRECTED  = 22;
  localparam int NUM_PHASES    = 5;

  typedef struct {
    logic [31:0] off;
    logic [2:0]  cls;
    status_t     st;
  } alloc_result_t;

  typedef struct {
    func_t       func;
    logic [31:0] size;
    logic [31:0] foff;
    bit          typed;
    logic [31:0] want_off;
    logic [2:0]  want_cls;
    status_t     want_st;
  } req_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = 1'b0;
  logic [31:0] in_request_size = '0;
  logic [31:0] in_free_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_block_offset;
  logic [2:0]  out_size_class;
  logic [1:0]  out_status;

  logic [31:0]   stack_mem [STACK_DEPTH];
  int unsigned   fill_cnt [CLASS_COUNT];
  alloc_result_t pending_results [$];
  req_row_t      directed_rows [NUM_DIRECTED];
  int unsigned   mismatches = 0;
  int unsigned   snd_idle_pct = 0;
  int unsigned   rcv_stall_pct = 0;
  logic          hold_off = 1'b0;

  size_class_free_stack_allocator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_request_size  (in_request_size),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_block_offset (out_block_offset),
    .out_size_class   (out_size_class),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < rcv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  // allocator state update for one request; returns the result it yields
  function automatic alloc_result_t serve_request(input func_t f, input logic [31:0] size,
                                                  input logic [31:0] foff);
    alloc_result_t r;
    logic [31:0]   v;
    int            len;
    int            t;
    len = 0;
    if (size == 32'd0) begin
      len = 64;
    end else begin
      v = size - 32'd1;
      while (v != 32'd0) begin
        len++;
        v = v >> 1;
      end
    end
    t = (len - MIN_BITS + CLASS_STRIDE) / CLASS_STRIDE;
    if (t < 0) t = 0;
    r.cls = (t > 7) ? 3'd7 : 3'(t);
    r.off = '0;
    r.st  = STAT_OK;
    if (size == 32'd0 || t >= CLASS_COUNT) begin
      r.st = STAT_TOO_LARGE;
    end else if (f == FUNC_ALLOC) begin
      if (fill_cnt[t] == 0) begin
        r.st = STAT_EMPTY;
      end else begin
        fill_cnt[t]--;
        r.off = stack_mem[t * SLOTS_PER_ROW + fill_cnt[t]];
      end
    end else begin
      if (fill_cnt[t] >= SLOTS_PER_ROW) begin
        r.st = STAT_FULL;
      end else begin
        stack_mem[t * SLOTS_PER_ROW + fill_cnt[t]] = foff;
        fill_cnt[t]++;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] size_in_class(input int unsigned c);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = (c == 0) ? 32'd1 : (32'd1 << (MIN_BITS + (c - 1) * CLASS_STRIDE - 1)) + 32'd1;
    hi = 32'd1 << (MIN_BITS + c * CLASS_STRIDE - 1);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return lo + ($urandom % (hi - lo + 32'd1));
    endcase
  endfunction

  task automatic push_beat(input req_row_t row);
    alloc_result_t r;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= row.func;
    in_request_size <= row.size;
    in_free_offset  <= row.foff;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = serve_request(row.func, row.size, row.foff);
    if (row.typed) begin
      r.off = row.want_off;
      r.cls = row.want_cls;
      r.st  = row.want_st;
    end
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    alloc_result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat off=%h cls=%0d st=%0d",
                                  out_block_offset, out_size_class, out_status));
      end else begin
        w = pending_results.pop_front();
        if (out_block_offset !== w.off)
          report_mismatch($sformatf("block_offset %h, want %h", out_block_offset, w.off));
        if (out_size_class !== w.cls)
          report_mismatch($sformatf("size_class %0d, want %0d", out_size_class, w.cls));
        if (out_status !== w.st)
          report_mismatch($sformatf("status %0d, want %0d", out_status, w.st));
      end
    end
  end

  initial begin
    #3000000;
    $display("size_class_free_stack_allocator_unit_tb failed");
    $finish;
  end

  initial begin
    logic [63:0] offset;
    logic [63:0] block;
    req_row_t    row;
    int unsigned p;
    int unsigned i;
    int unsigned c;
    int unsigned pick;
    int unsigned alloc_pct;
    int unsigned fav_class;
    int unsigned phase_len [NUM_PHASES];
    int unsigned phase_snd [NUM_PHASES];
    int unsigned phase_rcv [NUM_PHASES];

    phase_len = '{300, 250, 250, 300, 400};
    phase_snd = '{0, 86, 0, 38, 0};
    phase_rcv = '{0, 0, 86, 38, 0};

    directed_rows = '{
      '{FUNC_FREE,  32'd128,        32'h12345678, 1'b1, 32'd0,    3'd0, STAT_FULL},
      '{FUNC_ALLOC, 32'd1,          32'h0,        1'b1, 32'd8064, 3'd0, STAT_OK},
      '{FUNC_ALLOC, 32'd128,        32'h0,        1'b0, 32'd0,    3'd0, STAT_OK},
      '{FUNC_ALLOC, 32'd129,        32'hFFFFFFFF, 1'b0, 32'd0,    3'd0, STAT_OK},
      '{FUNC_ALLOC, 32'd0,          32'h0,        1'b1, 32'd0,    3'd7, STAT_TOO_LARGE},
      '{FUNC_FREE,  32'd0,          32'hFFFFFFFF, 1'b1, 32'd0,    3'd7, STAT_TOO_LARGE},
      '{FUNC_ALLOC, 32'hFFFFFFFF,   32'h0,        1'b1, 32'd0,    3'd7, STAT_TOO_LARGE},
      '{FUNC_ALLOC, 32'd131073,     32'h0,        1'b1, 32'd0,    3'd6, STAT_TOO_LARGE},
      '{FUNC_FREE,  32'h00080000,   32'h55AA55AA, 1'b1, 32'd0,    3'd6, STAT_TOO_LARGE},
      '{FUNC_FREE,  32'h00080001,   32'hAA55AA55, 1'b1, 32'd0,    3'd7, STAT_TOO_LARGE},
      '{FUNC_ALLOC, 32'd131072,     32'h0,        1'b0, 32'd0,    3'd0, STAT_OK},
      '{FUNC_ALLOC, 32'd65537,      32'h0,        1'b0, 32'd0,    3'd0, STAT_OK},
      '{FUNC_ALLOC, 32'd131072,     32'h0,        1'b1, 32'd0,    3'd5, STAT_EMPTY},
      '{FUNC_FREE,  32'd131072,     32'hFFFFFFFF, 1'b0, 32'd0,    3'd0, STAT_OK},
      '{FUNC_FREE,  32'd32769,      32'h00000000, 1'b0, 32'd0,    3'd0, STAT_OK},
      '{FUNC_ALLOC, 32'd100000,     32'h0,        1'b0, 32'd0,    3'd0, STAT_OK},
      '{FUNC_ALLOC, 32'd131072,     32'h0,        1'b0, 32'd0,    3'd0, STAT_OK},
      '{FUNC_FREE,  32'd1,          32'hA5A5A5A5, 1'b0, 32'd0,    3'd0, STAT_OK},
      '{FUNC_ALLOC, 32'd2,          32'h0,        1'b0, 32'd0,    3'd0, STAT_OK},
      '{FUNC_FREE,  32'd128,        32'h5A5A5A5A, 1'b0, 32'd0,    3'd0, STAT_OK},
      '{FUNC_FREE,  32'd64,         32'hDEADBEEF, 1'b0, 32'd0,    3'd0, STAT_OK},
      '{FUNC_FREE,  32'd1,          32'h00000001, 1'b0, 32'd0,    3'd0, STAT_OK}
    };

    // packed reset layout, class 0 first
    offset = '0;
    block  = 64'd1 << (MIN_BITS - 1);
    for (c = 0; c < STACK_DEPTH; c++) stack_mem[c] = '0;
    for (c = 0; c < CLASS_COUNT; c++) begin
      fill_cnt[c] = SLOTS_PER_ROW >> c;
      for (i = 0; i < fill_cnt[c]; i++) begin
        stack_mem[c * SLOTS_PER_ROW + i] = offset[31:0];
        offset = offset + block;
      end
      block = block << CLASS_STRIDE;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct  = 38;
    rcv_stall_pct = 38;
    for (i = 0; i < NUM_DIRECTED; i++) push_beat(directed_rows[i]);

    alloc_pct = 50;
    fav_class = 0;
    for (p = 0; p < NUM_PHASES; p++) begin
      snd_idle_pct  = phase_snd[p];
      rcv_stall_pct = phase_rcv[p];
      if (p == NUM_PHASES - 1) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (400) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      for (i = 0; i < phase_len[p]; i++) begin
        if (i % 100 == 0) begin
          case ($urandom_range(0, 2))
            0:       alloc_pct = 15;
            1:       alloc_pct = 50;
            default: alloc_pct = 85;
          endcase
          fav_class = $urandom_range(0, CLASS_COUNT - 1);
        end
        row.typed    = 1'b0;
        row.want_off = '0;
        row.want_cls = '0;
        row.want_st  = STAT_OK;
        row.func     = ($urandom_range(0, 99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          row.size = $urandom;
        end else if (pick < 8) begin
          row.size = '0;
        end else if (pick < 12) begin
          row.size = size_in_class(CLASS_COUNT + $urandom_range(0, 1));
        end else if (pick < 70) begin
          row.size = size_in_class(fav_class);
        end else begin
          row.size = size_in_class($urandom_range(0, CLASS_COUNT - 1));
        end
        case ($urandom_range(0, 9))
          0:       row.foff = '0;
          1:       row.foff = '1;
          default: row.foff = $urandom;
        endcase
        push_beat(row);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("size_class_free_stack_allocator_unit_tb passed");
    end else begin
      $display("size_class_free_stack_allocator_unit_tb failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/scfsa_pkg.sv
rtl/scfsa_class.sv
rtl/size_class_free_stack_allocator_unit.sv
sim/size_class_free_stack_allocator_unit_tb.sv
